[rtl/biquad_iir_filter_unit_assert.svh]
// assertion macros shared by the biquad checker
`ifndef BIQUAD_IIR_FILTER_UNIT_ASSERT_SVH
`define BIQUAD_IIR_FILTER_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define BIQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("biquad check failed");

// consequent checked in the following cycle
`define BIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("biquad check failed");

`endif

[rtl/biq_pkg.sv]
// shared types and codes of the biquad filter
package biq_pkg;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_B0 = 3'd0;
    localparam t_cfg_idx CFG_B1 = 3'd1;
    localparam t_cfg_idx CFG_B2 = 3'd2;
    localparam t_cfg_idx CFG_A1 = 3'd3;
    localparam t_cfg_idx CFG_A2 = 3'd4;

    // input commands
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XPASS,
        ST_ACC,
        ST_ROUND,
        ST_YPASS,
        ST_FB,
        ST_UPD
    } t_state;

    // control of one serial multiply lane
    typedef struct packed {
        logic step;
        logic first;
    } t_lane_ctl;

endpackage

[rtl/biq_if.sv]
// stream and configuration interfaces of the biquad filter

// input sample channel
interface biq_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output command, output sample_in, input ready);
    modport sink   (input valid, input command, input sample_in, output ready);
endinterface

// output sample channel
interface biq_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// coefficient write channel
interface biq_cfg_if import biq_pkg::*; #(parameter int COEF_BITS = 24);
    logic                 valid;
    logic                 ready;
    t_cfg_idx             index;
    logic [COEF_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/biq_mac_lane.sv]
// serial-parallel multiplier lane, one multiplier bit per cycle while step is high, msb first
module biq_mac_lane import biq_pkg::*; #(
    parameter int COEF_BITS = 24,
    parameter int PROD_BITS = 40
) (
    input  logic                        i_clk,
    input  t_lane_ctl                   i_ctl,
    input  logic                        i_bit,
    input  logic signed [COEF_BITS-1:0] i_coef,
    output logic signed [PROD_BITS-1:0] o_prod
);

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [PROD_BITS-1:0] n_prod;
    logic signed [PROD_BITS-1:0] coef_ext;

    assign coef_ext = PROD_BITS'(i_coef);

    // horner step: the sign bit weighs negative, later bits double and add
    always_comb begin
        if (i_ctl.first) begin
            n_prod = i_bit ? -coef_ext : '0;
        end else begin
            n_prod = (r_prod <<< 1) + (i_bit ? coef_ext : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

[rtl/biquad_iir_filter_unit.sv]
// top level of the biquad filter: sequencer, delay state and coefficient registers
// Transposed direct form II biquad with Q4.20 coefficients and saturating 40-bit
// delay state. A filter beat holds the sequencer, and no new input is taken until
// it returns to idle: the input sample is shifted msb first through three serial
// multiply lanes (b0, b1, b2), an accumulate step and a rounding step form and
// round the output, the rounded output is shifted through two more lanes (a1, a2),
// and a feedback step and an update step update the delay state. The output is
// posted when it is formed; the sequencer holds in its rounding step only while a
// previous output beat is still waiting. A clear beat leaves the sequencer idle
// and produces no output.
// Coefficient writes are taken every cycle.
module biquad_iir_filter_unit import biq_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    biq_in_if.sink          i_in,
    biq_out_if.source       o_out,
    biq_cfg_if.sink         i_cfg
);

    localparam int STATE_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int AW         = STATE_BITS + 3;
    localparam int FRAC       = COEF_BITS - 4;
    localparam int CW         = $clog2(SAMPLE_BITS);

    localparam logic signed [AW-1:0] ONE    = {{(AW-1){1'b0}}, 1'b1};
    localparam logic signed [AW-1:0] I64_HI = (ONE << 63) - ONE;
    localparam logic signed [AW-1:0] I64_LO = ~I64_HI;
    localparam logic signed [AW-1:0] ST_HI  = (ONE << (STATE_BITS-1)) - ONE;
    localparam logic signed [AW-1:0] ST_LO  = ~ST_HI;
    localparam logic signed [AW-1:0] SMP_HI = (ONE << (SAMPLE_BITS-1)) - ONE;
    localparam logic signed [AW-1:0] SMP_LO = ~SMP_HI;
    localparam logic signed [AW-1:0] HALF   = ONE << (FRAC-1);
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << FRAC;

    // clamp to the signed 64-bit range
    function automatic logic signed [AW-1:0] sat64(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        r = v;
        if (AW > 64) begin
            if (v > I64_HI) begin
                r = I64_HI;
            end else if (v < I64_LO) begin
                r = I64_LO;
            end
        end
        return r;
    endfunction

    // clamp to the delay state width
    function automatic logic signed [STATE_BITS-1:0] sat_st(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        r = v;
        if (v > ST_HI) begin
            r = ST_HI;
        end else if (v < ST_LO) begin
            r = ST_LO;
        end
        return STATE_BITS'(r);
    endfunction

    t_state r_state;
    t_state n_state;

    logic signed [COEF_BITS-1:0]  r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [STATE_BITS-1:0] r_d1, r_d2;
    logic signed [SAMPLE_BITS-1:0] r_x, r_y;
    logic [CW-1:0]                r_cnt;
    logic signed [AW-1:0]         r_acc, r_t1, r_t2;
    logic                         r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    logic signed [STATE_BITS-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    t_lane_ctl                    x_ctl, y_ctl;
    logic                         in_beat, cnt_last, round_go;
    logic signed [AW-1:0]         rnd_sum, rnd_shift, y_full;
    logic signed [SAMPLE_BITS-1:0] y_val;

    assign in_beat  = i_in.valid && i_in.ready;
    assign cnt_last = (r_cnt == CW'(SAMPLE_BITS-1));
    assign round_go = (r_state == ST_ROUND) && (!r_out_valid || o_out.ready);

    // handshake outputs
    assign i_in.ready       = (r_state == ST_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

    // lane control for the two serial passes
    assign x_ctl.step  = (r_state == ST_XPASS);
    assign x_ctl.first = (r_cnt == '0);
    assign y_ctl.step  = (r_state == ST_YPASS);
    assign y_ctl.first = (r_cnt == '0);

    biq_mac_lane #(.COEF_BITS(COEF_BITS), .PROD_BITS(STATE_BITS)) u_lane_b0 (
        .i_clk(i_clk), .i_ctl(x_ctl), .i_bit(r_x[SAMPLE_BITS-1]),
        .i_coef(r_b0), .o_prod(p_b0)
    );
    biq_mac_lane #(.COEF_BITS(COEF_BITS), .PROD_BITS(STATE_BITS)) u_lane_b1 (
        .i_clk(i_clk), .i_ctl(x_ctl), .i_bit(r_x[SAMPLE_BITS-1]),
        .i_coef(r_b1), .o_prod(p_b1)
    );
    biq_mac_lane #(.COEF_BITS(COEF_BITS), .PROD_BITS(STATE_BITS)) u_lane_b2 (
        .i_clk(i_clk), .i_ctl(x_ctl), .i_bit(r_x[SAMPLE_BITS-1]),
        .i_coef(r_b2), .o_prod(p_b2)
    );
    biq_mac_lane #(.COEF_BITS(COEF_BITS), .PROD_BITS(STATE_BITS)) u_lane_a1 (
        .i_clk(i_clk), .i_ctl(y_ctl), .i_bit(r_y[SAMPLE_BITS-1]),
        .i_coef(r_a1), .o_prod(p_a1)
    );
    biq_mac_lane #(.COEF_BITS(COEF_BITS), .PROD_BITS(STATE_BITS)) u_lane_a2 (
        .i_clk(i_clk), .i_ctl(y_ctl), .i_bit(r_y[SAMPLE_BITS-1]),
        .i_coef(r_a2), .o_prod(p_a2)
    );

    // round half up, drop the fraction, saturate to the sample range
    always_comb begin
        rnd_sum   = sat64(r_acc + HALF);
        rnd_shift = rnd_sum >>> FRAC;
        y_full    = rnd_shift;
        if (rnd_shift > SMP_HI) begin
            y_full = SMP_HI;
        end else if (rnd_shift < SMP_LO) begin
            y_full = SMP_LO;
        end
        y_val = SAMPLE_BITS'(y_full);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_beat && (i_in.command == CMD_FILTER)) begin
                    n_state = ST_XPASS;
                end
            end
            ST_XPASS: begin
                if (cnt_last) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC:   n_state = ST_ROUND;
            ST_ROUND: begin
                if (round_go) begin
                    n_state = ST_YPASS;
                end
            end
            ST_YPASS: begin
                if (cnt_last) begin
                    n_state = ST_FB;
                end
            end
            ST_FB:    n_state = ST_UPD;
            ST_UPD:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x   <= i_in.sample_in;
                r_cnt <= '0;
            end
            ST_XPASS: begin
                r_x   <= r_x <<< 1;
                r_cnt <= cnt_last ? '0 : r_cnt + CW'(1);
            end
            ST_ACC: begin
                r_acc <= sat64(AW'(p_b0) + AW'(r_d1));
            end
            ST_ROUND: begin
                r_y   <= y_val;
                r_cnt <= '0;
            end
            ST_YPASS: begin
                r_y   <= r_y <<< 1;
                r_cnt <= cnt_last ? '0 : r_cnt + CW'(1);
            end
            ST_FB: begin
                r_t1 <= AW'(p_b1) - AW'(p_a1);
                r_t2 <= AW'(p_b2) - AW'(p_a2);
            end
            default: begin
            end
        endcase
    end

    // delay state: cleared by command, updated at the end of a filter beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (in_beat && (i_in.command == CMD_CLEAR)) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (r_state == ST_UPD) begin
            r_d1 <= sat_st(r_t1 + AW'(r_d2));
            r_d2 <= sat_st(r_t2);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (round_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (round_go) begin
            r_out_data <= y_val;
        end
    end

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= COEF_ONE;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_B0:  r_b0 <= i_cfg.data;
                CFG_B1:  r_b1 <= i_cfg.data;
                CFG_B2:  r_b2 <= i_cfg.data;
                CFG_A1:  r_a1 <= i_cfg.data;
                CFG_A2:  r_a2 <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/biq_checker.sv]
// port-level checks of the biquad filter and their binding
`include "biquad_iir_filter_unit_assert.svh"

module biq_checker import biq_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_command,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_out_sample
);

    // a stalled output beat holds its value
    `BIQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_sample))

    // a filter beat occupies the sequencer, so input is not taken next cycle
    `BIQ_ASSERT_NEXT(a_filter_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_command == CMD_FILTER), !i_in_ready)

    // a clear beat finishes at once, so input is ready again in the next cycle
    `BIQ_ASSERT_NEXT(a_clear_quick, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_command == CMD_CLEAR), i_in_ready)

    // a new output appears only while a sample is still being worked on
    `BIQ_ASSERT_NOW(a_out_in_work, i_clk, i_rst_n, $rose(i_out_valid), !i_in_ready)

endmodule

bind biquad_iir_filter_unit biq_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_biq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out)
);
